// ===== src/tleh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tleh_pkg;

    localparam int LINE_BYTES    = 32;
    localparam int HISTORY_LINES = 8;

    localparam int LEN_W   = $clog2(LINE_BYTES + 1);
    localparam int IDX_W   = $clog2(LINE_BYTES);
    localparam int HCNT_W  = $clog2(HISTORY_LINES + 1);
    localparam int SLOT_W  = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int HDEPTH  = HISTORY_LINES * LINE_BYTES;
    localparam int HADDR_W = $clog2(HDEPTH);

    localparam logic [7:0] BYTE_ESC   = 8'h1b;
    localparam logic [7:0] BYTE_CSI   = 8'h5b;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_DOWN  = 8'h42;
    localparam logic [7:0] BYTE_RIGHT = 8'h43;
    localparam logic [7:0] BYTE_LEFT  = 8'h44;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_DEL   = 8'h7f;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [1:0] PHASE_NORMAL = 2'd0;
    localparam logic [1:0] PHASE_ESC    = 2'd1;
    localparam logic [1:0] PHASE_CSI    = 2'd2;

    localparam logic [2:0] KIND_ECHO     = 3'd0;
    localparam logic [2:0] KIND_ERASE    = 3'd1;
    localparam logic [2:0] KIND_RECALL   = 3'd2;
    localparam logic [2:0] KIND_DONE     = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;

    localparam logic [2:0] EMIT_NONE = 3'd0;
    localparam logic [2:0] EMIT_HDR  = 3'd1;
    localparam logic [2:0] EMIT_BYTE = 3'd2;
    localparam logic [2:0] EMIT_ECHO = 3'd3;
    localparam logic [2:0] EMIT_OVF  = 3'd4;
    localparam logic [2:0] EMIT_ERS  = 3'd5;

    typedef struct packed {
        logic       latch_rx;
        logic       set_phase;
        logic [1:0] phase_val;
        logic       recall_up;
        logic       recall_down;
        logic       start_done;
        logic       rd_issue;
        logic       copy_write;
        logic       append;
        logic       erase;
        logic       finish;
        logic [2:0] emit_sel;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] rx;
        logic [1:0] phase;
        logic       len_zero;
        logic       len_near_full;
        logic       pos_zero;
        logic       used_zero;
        logic       copy_zero;
        logic       idx_last;
        logic       out_free;
    } t_stat;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                                  input logic [HCNT_W-1:0] logical);
        logic [HCNT_W:0] sum;
        sum = (HCNT_W+1)'(oldest) + (HCNT_W+1)'(logical);
        if (sum >= (HCNT_W+1)'(HISTORY_LINES))
            sum = sum - (HCNT_W+1)'(HISTORY_LINES);
        return SLOT_W'(sum);
    endfunction

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [IDX_W-1:0] idx);
        return HADDR_W'(HADDR_W'(slot) * HADDR_W'(LINE_BYTES)) + HADDR_W'(idx);
    endfunction

endpackage
`default_nettype wire

// ===== src/tleh_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tleh_dpath import tleh_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cmd       i_cmd,
    output t_stat           o_stat,
    input  wire logic       i_ev_ready,
    output logic            o_ev_valid,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_present,
    output logic            o_last_of_run
);

    logic [7:0]        r_rx;
    logic [1:0]        r_phase;
    logic [LEN_W-1:0]  r_len;
    logic [HCNT_W-1:0] r_used;
    logic [SLOT_W-1:0] r_oldest;
    logic [HCNT_W-1:0] r_pos;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_copylen;
    logic [IDX_W-1:0]  r_idx;
    logic              r_mode_recall;
    logic              r_full;
    logic [7:0]        r_hist_q;
    logic [7:0]        r_edit_q;
    logic              r_ev_valid;
    logic [2:0]        r_kind;
    logic [7:0]        r_data;
    logic              r_present;
    logic              r_last;

    logic [7:0]        m_edit [LINE_BYTES];
    logic [7:0]        m_hist [HDEPTH];
    logic [LEN_W-1:0]  m_hlen [HISTORY_LINES];

    logic [HCNT_W-1:0] n_pos;
    logic [SLOT_W-1:0] n_slot;
    logic [LEN_W-1:0]  n_len_inc;
    logic [7:0]        rdata;
    logic [2:0]        line_kind;

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.recall_up) begin
            n_pos = r_pos - HCNT_W'(1);
        end else if (r_pos + HCNT_W'(1) < r_used) begin
            n_pos = r_pos + HCNT_W'(1);
        end else begin
            n_pos = r_used - HCNT_W'(1);
        end
    end

    assign n_slot    = slot_of(r_oldest, n_pos);
    assign n_len_inc = r_len + LEN_W'(1);
    assign rdata     = r_mode_recall ? r_hist_q : r_edit_q;
    assign line_kind = r_mode_recall ? KIND_RECALL : KIND_DONE;

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_hist_q <= m_hist[hist_addr(r_slot, r_idx)];
            r_edit_q <= m_edit[r_idx];
        end
        if (i_cmd.append) begin
            m_edit[r_len[IDX_W-1:0]] <= r_rx;
        end else if (i_cmd.copy_write && r_mode_recall) begin
            m_edit[r_idx] <= rdata;
        end
        if (i_cmd.copy_write && !r_mode_recall) begin
            m_hist[hist_addr(r_slot, r_idx)] <= rdata;
        end
        if (i_cmd.finish && !r_mode_recall && r_copylen != '0) begin
            m_hlen[r_slot] <= r_copylen;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PHASE_NORMAL;
            r_len      <= '0;
            r_used     <= '0;
            r_oldest   <= '0;
            r_pos      <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            if (i_cmd.set_phase) r_phase <= i_cmd.phase_val;
            if (i_cmd.recall_up || i_cmd.recall_down) r_pos <= n_pos;
            if (i_cmd.append) r_len <= (n_len_inc == LEN_W'(LINE_BYTES)) ? '0 : n_len_inc;
            if (i_cmd.erase) r_len <= r_len - LEN_W'(1);
            if (i_cmd.finish) begin
                if (r_mode_recall) begin
                    r_len <= r_copylen;
                end else begin
                    r_len <= '0;
                    if (r_copylen != '0) begin
                        if (r_full) begin
                            r_oldest <= (r_oldest == SLOT_W'(HISTORY_LINES - 1)) ?
                                        '0 : r_oldest + SLOT_W'(1);
                            r_pos    <= r_used;
                        end else begin
                            r_used <= r_used + HCNT_W'(1);
                            r_pos  <= r_used + HCNT_W'(1);
                        end
                    end
                end
            end
            if (i_cmd.emit_sel != EMIT_NONE) r_ev_valid <= 1'b1;
            else if (i_ev_ready) r_ev_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_rx) r_rx <= i_rx_byte;
        if (i_cmd.recall_up || i_cmd.recall_down) begin
            r_slot        <= n_slot;
            r_copylen     <= m_hlen[n_slot];
            r_mode_recall <= 1'b1;
        end
        if (i_cmd.start_done) begin
            r_mode_recall <= 1'b0;
            r_copylen     <= r_len;
            r_full        <= (r_used >= HCNT_W'(HISTORY_LINES));
            r_slot        <= (r_used >= HCNT_W'(HISTORY_LINES)) ? r_oldest :
                             slot_of(r_oldest, r_used);
        end
        if (i_cmd.emit_sel == EMIT_HDR) r_idx <= '0;
        else if (i_cmd.copy_write) r_idx <= r_idx + IDX_W'(1);
        case (i_cmd.emit_sel)
            EMIT_HDR: begin
                r_kind <= line_kind; r_data <= 8'd0; r_present <= 1'b0;
            end
            EMIT_BYTE: begin
                r_kind <= line_kind; r_data <= rdata; r_present <= 1'b1;
            end
            EMIT_ECHO: begin
                r_kind <= KIND_ECHO; r_data <= r_rx; r_present <= 1'b1;
            end
            EMIT_OVF: begin
                r_kind <= KIND_OVERFLOW; r_data <= 8'd0; r_present <= 1'b0;
            end
            EMIT_ERS: begin
                r_kind <= KIND_ERASE; r_data <= 8'd0; r_present <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.emit_sel != EMIT_NONE) r_last <= i_cmd.last;
    end

    always_comb begin
        o_stat.rx            = r_rx;
        o_stat.phase         = r_phase;
        o_stat.len_zero      = (r_len == '0);
        o_stat.len_near_full = (r_len == LEN_W'(LINE_BYTES - 1));
        o_stat.pos_zero      = (r_pos == '0);
        o_stat.used_zero     = (r_used == '0);
        o_stat.copy_zero     = (r_copylen == '0);
        o_stat.idx_last      = ((LEN_W'(r_idx) + LEN_W'(1)) == r_copylen);
        o_stat.out_free      = !r_ev_valid || i_ev_ready;
    end

    assign o_ev_valid     = r_ev_valid;
    assign o_event_kind   = r_kind;
    assign o_data_byte    = r_data;
    assign o_byte_present = r_present;
    assign o_last_of_run  = r_last;

endmodule
`default_nettype wire

// ===== src/tleh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tleh_ctrl import tleh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_rx_valid,
    output logic       o_rx_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_HDR    = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_BYTE   = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_ECHO   = 4'd6;
    localparam logic [3:0] S_OVF    = 4'd7;
    localparam logic [3:0] S_ERS    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_ovf, n_ovf;
    logic       normal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    assign o_rx_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ovf   = r_ovf;
        normal  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_rx_valid) begin
                    o_cmd.latch_rx = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state         = S_IDLE;
                o_cmd.set_phase = 1'b1;
                o_cmd.phase_val = PHASE_NORMAL;
                if (i_stat.rx == BYTE_ESC) begin
                    o_cmd.phase_val = PHASE_ESC;
                end else if (i_stat.phase == PHASE_ESC) begin
                    if (i_stat.rx == BYTE_CSI) o_cmd.phase_val = PHASE_CSI;
                    else normal = 1'b1;
                end else if (i_stat.phase == PHASE_CSI) begin
                    if (i_stat.rx == BYTE_UP) begin
                        if (!i_stat.pos_zero) begin
                            o_cmd.recall_up = 1'b1;
                            n_state = S_HDR;
                        end
                    end else if (i_stat.rx == BYTE_DOWN) begin
                        if (!i_stat.used_zero) begin
                            o_cmd.recall_down = 1'b1;
                            n_state = S_HDR;
                        end
                    end else if (!(i_stat.rx inside {BYTE_RIGHT, BYTE_LEFT})) begin
                        normal = 1'b1;
                    end
                end else begin
                    normal = 1'b1;
                end
                if (normal) begin
                    if (i_stat.rx inside {BYTE_CR, BYTE_LF}) begin
                        o_cmd.start_done = 1'b1;
                        n_state = S_HDR;
                    end else if (i_stat.rx inside {BYTE_BS, BYTE_DEL}) begin
                        if (!i_stat.len_zero) begin
                            o_cmd.erase = 1'b1;
                            n_state = S_ERS;
                        end
                    end else if (i_stat.rx >= BYTE_SPACE) begin
                        o_cmd.append = 1'b1;
                        n_ovf   = i_stat.len_near_full;
                        n_state = S_ECHO;
                    end
                end
            end
            S_HDR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sel = EMIT_HDR;
                    o_cmd.last     = i_stat.copy_zero;
                    n_state = i_stat.copy_zero ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_BYTE;
            end
            S_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sel   = EMIT_BYTE;
                    o_cmd.last       = i_stat.idx_last;
                    o_cmd.copy_write = 1'b1;
                    n_state = i_stat.idx_last ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            S_ECHO: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sel = EMIT_ECHO;
                    o_cmd.last     = !r_ovf;
                    n_state = r_ovf ? S_OVF : S_IDLE;
                end
            end
            S_OVF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sel = EMIT_OVF;
                    o_cmd.last     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ERS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sel = EMIT_ERS;
                    o_cmd.last     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/terminal_line_editor_history_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                                      | Direction
// rx      | i_rx_valid, o_rx_ready, i_rx_byte          | in, one terminal byte per transaction
// event   | o_ev_valid, i_ev_ready, o_event_kind,      | out, one editor event per transaction
//         | o_data_byte, o_byte_present, o_last_of_run |
//
// One byte is processed at a time: it is taken, then decoded, then the echo, erase
// or overflow events that it causes are emitted one after another. Recall and line
// done add a header event, a memory read then an emit and write for each copied
// byte, and a closing step; a line holds at most LINE_BYTES - 1 bytes. Synchronous
// active-low reset empties the edit line and the history; the text stores are not
// cleared. A stall on the event side holds the sequencer, and no new byte is taken
// until the run finishes.
module terminal_line_editor_history_unit import tleh_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_ev_valid,
    input  wire logic       i_ev_ready,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_present,
    output logic            o_last_of_run
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence escape decoding, recall and line copies
    tleh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold edit line, history ring and the event output register
    tleh_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_ev_ready     (i_ev_ready),
        .o_ev_valid     (o_ev_valid),
        .o_event_kind   (o_event_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_present (o_byte_present),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire
